FILE: hw/rtl/mmsr_pkg.sv
// ============================================================================
// mmsr_pkg
// Shared types and constants of the multi-motor speed ramp.
// ============================================================================
package mmsr_pkg;

   localparam int MOTORS    = 8;
   localparam int FRAC_BITS = 8;
   localparam int MOT_W     = (MOTORS > 1) ? $clog2(MOTORS) : 1;

   localparam int VAL_W     = 16;
   localparam int RATE_W    = 10;
   localparam int ACC_W     = 15;
   localparam int MAXS_W    = 14;
   localparam int MOTO_W    = 3;
   localparam int SET_W     = VAL_W + FRAC_BITS + 1;
   localparam int STEP_W    = ACC_W + FRAC_BITS;
   localparam int DIV_W     = STEP_W;
   localparam int CNT_W     = $clog2(DIV_W + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(50);
   localparam logic [ACC_W-1:0]  ACCEL_RESET = ACC_W'(144);

   localparam logic [1:0] CMD_TICK       = 2'd0;
   localparam logic [1:0] CMD_SET_TARGET = 2'd1;
   localparam logic [1:0] CMD_SET_ACCEL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_RATE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_ACCEL = CSR_IDX_W'(1);

   typedef struct packed {
      logic [1:0]              cmd;
      logic [2:0]              motor;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [MOTO_W-1:0]       motor_out;
      logic [MAXS_W-1:0]       max_speed;
      logic signed [VAL_W-1:0] travel_step;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] target;
      logic signed [SET_W-1:0] ramped;
   } spd_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_STEP_DIV,
      ST_UPDATE,
      ST_TRAV_DIV,
      ST_EMIT
   } state_type;

endpackage

FILE: hw/rtl/multi_motor_speed_ramp_top.sv
// ============================================================================
// multi_motor_speed_ramp_top
// Slew-rate limiter over a table of motors held in on-chip memories.
// ============================================================================
// A set-target or set-acceleration request is written in the cycle it is
// accepted and busy stays low. A tick request walks all motors, taking per
// motor a memory read, a load, a radix-2 divider run for the ramp step, an
// update/write-back, a divider run for the travel, and a result. The single
// shared divider serves both runs. Results appear one per motor, one cycle
// each, marked by rsp_strobe; the receiver cannot stall them, so it must
// take every strobe. Configuration writes are always ready.
// ============================================================================
module multi_motor_speed_ramp_top import mmsr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_strobe,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Speed table and acceleration table; valid bits give the reset values.
   spd_entry_type           spd_mem [MOTORS];
   logic [ACC_W-1:0]        acc_mem [MOTORS];
   spd_entry_type           spd_rd_ff;
   logic [ACC_W-1:0]        acc_rd_ff;
   logic [MOTORS-1:0]       spd_vld_ff;
   logic [MOTORS-1:0]       acc_vld_ff;

   logic [RATE_W-1:0]       rate_ff;
   logic [ACC_W-1:0]        dacc_ff;

   state_type               state_ff, state_in;
   logic [MOT_W-1:0]        idx_ff;

   logic signed [VAL_W-1:0] tgt_ff;
   logic signed [SET_W-1:0] set_ff;
   logic [MAXS_W-1:0]       half_ff;
   logic                    neg_ff;

   logic [DIV_W-1:0]        dq_ff, dq_in;
   logic [RATE_W-1:0]       drem_ff, rem_in;
   logic [CNT_W-1:0]        dcnt_ff;

   logic                    accept;
   logic                    set_ok;
   logic                    div_run;
   logic [RATE_W-1:0]       rate_eff;
   logic [RATE_W:0]         trial;
   logic                    trial_ge;

   logic signed [VAL_W-1:0] ld_tgt;
   logic signed [SET_W-1:0] ld_set;
   logic [ACC_W-1:0]        ld_acc;

   logic [STEP_W-1:0]       step;
   logic signed [SET_W-1:0] tgt_fx;
   logic signed [SET_W:0]   diff;
   logic [SET_W:0]          adiff;
   logic signed [SET_W-1:0] step_s;
   logic signed [SET_W-1:0] set_in;
   logic [SET_W-1:0]        abs_new;
   logic [SET_W-1:0]        half_full;
   logic [VAL_W-1:0]        mag_trv;

   logic [VAL_W-1:0]        quo;
   logic [VAL_W:0]          quo_neg;
   logic                    last;

   assign accept    = start && !busy;
   assign set_ok    = 32'(req_payload.motor) < MOTORS;
   assign csr_ready = 1'b1;
   assign rate_eff  = (rate_ff == '0) ? RATE_W'(1) : rate_ff;
   assign last      = (idx_ff == MOT_W'(MOTORS - 1));

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      div_run  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_payload.cmd == CMD_TICK) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_STEP_DIV;
         ST_STEP_DIV: begin
            div_run = 1'b1;
            if (dcnt_ff == CNT_W'(1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_TRAV_DIV;
         ST_TRAV_DIV: begin
            div_run = 1'b1;
            if (dcnt_ff == CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            state_in = last ? ST_IDLE : ST_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         dcnt_ff    <= '0;
         spd_vld_ff <= '0;
         acc_vld_ff <= '0;
         rate_ff    <= RATE_RESET;
         dacc_ff    <= ACCEL_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE) begin
            idx_ff <= '0;
         end else if (state_ff == ST_EMIT) begin
            idx_ff <= idx_ff + MOT_W'(1);
         end
         if (state_ff == ST_LOAD) begin
            dcnt_ff <= CNT_W'(STEP_W);
         end else if (state_ff == ST_UPDATE) begin
            dcnt_ff <= CNT_W'(VAL_W);
         end else if (div_run) begin
            dcnt_ff <= dcnt_ff - CNT_W'(1);
         end
         if (accept && set_ok && req_payload.cmd == CMD_SET_TARGET) begin
            spd_vld_ff[req_payload.motor[MOT_W-1:0]] <= 1'b1;
         end
         if (state_ff == ST_UPDATE) begin
            spd_vld_ff[idx_ff] <= 1'b1;
         end
         if (accept && set_ok && req_payload.cmd == CMD_SET_ACCEL) begin
            acc_vld_ff[req_payload.motor[MOT_W-1:0]] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LOOP_RATE) begin
               rate_ff <= csr_wdata[RATE_W-1:0];
            end else if (csr_index == CSR_DEFAULT_ACCEL) begin
               dacc_ff    <= csr_wdata[ACC_W-1:0];
               acc_vld_ff <= '0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      spd_rd_ff <= spd_mem[idx_ff];
      acc_rd_ff <= acc_mem[idx_ff];
      if (state_ff == ST_UPDATE) begin
         spd_mem[idx_ff] <= '{target: tgt_ff, ramped: set_in};
      end else if (accept && set_ok && req_payload.cmd == CMD_SET_TARGET) begin
         // A fresh entry needs its ramped speed cleared along with the target.
         if (spd_vld_ff[req_payload.motor[MOT_W-1:0]]) begin
            spd_mem[req_payload.motor[MOT_W-1:0]].target <= req_payload.value;
         end else begin
            spd_mem[req_payload.motor[MOT_W-1:0]] <=
               '{target: req_payload.value, ramped: '0};
         end
      end
      if (accept && set_ok && req_payload.cmd == CMD_SET_ACCEL) begin
         acc_mem[req_payload.motor[MOT_W-1:0]] <=
            req_payload.value[VAL_W-1] ? '0 : req_payload.value[ACC_W-1:0];
      end
   end

   assign ld_tgt = spd_vld_ff[idx_ff] ? spd_rd_ff.target : '0;
   assign ld_set = spd_vld_ff[idx_ff] ? spd_rd_ff.ramped : '0;
   assign ld_acc = acc_vld_ff[idx_ff] ? acc_rd_ff : dacc_ff;

   // ---------------------------------------------------------------- divider
   assign trial    = {drem_ff, dq_ff[DIV_W-1]};
   assign trial_ge = (trial >= {1'b0, rate_eff});
   assign rem_in   = trial_ge ? RATE_W'(trial - {1'b0, rate_eff}) : RATE_W'(trial);
   assign dq_in    = {dq_ff[DIV_W-2:0], trial_ge};

   // ---------------------------------------------------------------- ramp update
   assign step   = dq_ff[STEP_W-1:0];
   assign tgt_fx = {{(SET_W-VAL_W-FRAC_BITS){tgt_ff[VAL_W-1]}}, tgt_ff,
                    {FRAC_BITS{1'b0}}};
   assign diff   = {tgt_fx[SET_W-1], tgt_fx} - {set_ff[SET_W-1], set_ff};
   assign adiff  = diff[SET_W] ? (SET_W+1)'(-diff) : (SET_W+1)'(diff);
   assign step_s = $signed({{(SET_W-STEP_W){1'b0}}, step});

   always_comb begin
      if (tgt_ff == '0) begin
         set_in = '0;
      end else if (adiff <= (SET_W+1)'(step)) begin
         set_in = tgt_fx;
      end else if (!diff[SET_W]) begin
         set_in = set_ff + step_s;
      end else begin
         set_in = set_ff - step_s;
      end
   end

   assign abs_new   = set_in[SET_W-1] ? SET_W'(-set_in) : SET_W'(set_in);
   assign half_full = abs_new >> (FRAC_BITS + 1);
   assign mag_trv   = VAL_W'(abs_new >> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         tgt_ff  <= ld_tgt;
         set_ff  <= ld_set;
         dq_ff   <= {ld_acc, {FRAC_BITS{1'b0}}};
         drem_ff <= '0;
      end else if (state_ff == ST_UPDATE) begin
         set_ff  <= set_in;
         neg_ff  <= set_in[SET_W-1];
         half_ff <= (half_full > SET_W'((1 << MAXS_W) - 1)) ? {MAXS_W{1'b1}}
                                                            : MAXS_W'(half_full);
         dq_ff   <= {mag_trv, {(DIV_W-VAL_W){1'b0}}};
         drem_ff <= '0;
      end else if (div_run) begin
         dq_ff   <= dq_in;
         drem_ff <= rem_in;
      end
   end

   // ---------------------------------------------------------------- result
   assign quo     = dq_ff[VAL_W-1:0];
   assign quo_neg = -{1'b0, quo};

   always_comb begin
      rsp_strobe            = (state_ff == ST_EMIT);
      rsp_payload.motor_out = MOTO_W'(idx_ff);
      rsp_payload.max_speed = half_ff;
      rsp_payload.last      = last;
      if (neg_ff) begin
         rsp_payload.travel_step = $signed(quo_neg[VAL_W-1:0]);
      end else if (quo[VAL_W-1]) begin
         rsp_payload.travel_step = $signed({1'b0, {(VAL_W-1){1'b1}}});
      end else begin
         rsp_payload.travel_step = $signed(quo);
      end
   end

endmodule

FILE: hw/rtl/mmsr_check.sv
// ============================================================================
// mmsr_check
// Port-level checks on the request and result timing of the speed ramp.
// ============================================================================
module mmsr_check import mmsr_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   // Results only come out while a tick is being worked on.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result strobe while not busy");

   // An accepted tick request makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.cmd == CMD_TICK) |=> busy)
      else $error("tick request did not start a walk");

   // Set requests complete in the cycle they are accepted.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.cmd != CMD_TICK) |=> !busy)
      else $error("set request left the block busy");

   // Each motor needs several divider cycles, so strobes never come back to back.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   // The final result of a tick ends the walk.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.last) |=> !busy)
      else $error("block still busy after the last result");

endmodule

bind multi_motor_speed_ramp_top mmsr_check u_mmsr_check (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
